@@ design/binary_grid_neighbor_smoothing_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary grid smoothing block
// Immediate-implication and next-cycle-implication checks, reset-gated.
// ----------------------------------------------------------------------------
`ifndef BINARY_GRID_NEIGHBOR_SMOOTHING_TOP_MACROS_SVH
`define BINARY_GRID_NEIGHBOR_SMOOTHING_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BGNS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BGNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bgns_pkg.sv @@
// ----------------------------------------------------------------------------
// bgns_pkg
// Shared types, codes and helpers of the binary grid smoothing block.
// ----------------------------------------------------------------------------
`default_nettype none

package bgns_pkg;

  // Configuration port
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 8'd128;

  // Item codes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Size defaults and limits
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DIM_MIN        = 3;

  // A window count above this makes a non-border cell floor
  localparam int FLOOR_LIMIT = 4;

  // Window sum holds 0..9
  localparam int SUM_W = 4;

  typedef logic [SUM_W-1:0] win_sum_t;

  // One window column: bit 0 two rows up, bit 1 one row up, bit 2 current row
  typedef logic [2:0] win_col_t;

  // One line buffer entry: the same column in the two previous rows
  typedef struct packed {
    logic older;
    logic newer;
  } lb_entry_t;

  function automatic win_sum_t col_ones(input win_col_t col);
    col_ones = SUM_W'(col[0]) + SUM_W'(col[1]) + SUM_W'(col[2]);
  endfunction

endpackage

`default_nettype wire

@@ design/bgns_cell.sv @@
// ----------------------------------------------------------------------------
// bgns_cell
// One window column cell: holds a column, hands it on, adds its floor count.
// ----------------------------------------------------------------------------
`default_nettype none

module bgns_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift_en,
  input  bgns_pkg::win_col_t col_in,
  input  bgns_pkg::win_sum_t sum_in,
  output bgns_pkg::win_col_t col,
  output bgns_pkg::win_sum_t sum_out
);
  import bgns_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift_en) begin
      col <= col_in;
    end
  end

  // Running window count along the chain
  assign sum_out = sum_in + col_ones(col);

endmodule

`default_nettype wire

@@ design/bgns_line_buf.sv @@
// ----------------------------------------------------------------------------
// bgns_line_buf
// Two-row line buffer: one read and one write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgns_line_buf #(
  parameter int DEPTH = bgns_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  bgns_pkg::lb_entry_t        wr_data,
  output bgns_pkg::lb_entry_t        rd_data
);
  import bgns_pkg::*;

  lb_entry_t mem [DEPTH];
  lb_entry_t rd_q;
  lb_entry_t fwd_data;
  logic      fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // Bypass a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

`default_nettype wire

@@ design/binary_grid_neighbor_smoothing_top.sv @@
// ----------------------------------------------------------------------------
// binary_grid_neighbor_smoothing_top: 3x3 floor-count smoothing of a binary grid
// An item passes stage 1 and the output register before its result is offered.
// Throughput: 1 item per cycle; the input stalls only while a result waits in
// stage 1 behind a held output register.
// Reset: clears counters, window and valid flags; size registers return to 128.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_grid_neighbor_smoothing_top_macros.svh"

module binary_grid_neighbor_smoothing_top #(
  parameter int MAX_WIDTH  = bgns_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bgns_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic                              cell_is_floor,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_is_floor,
  output logic                              last_cell,
  // configuration write port
  input  logic                              cfg_write_en,
  input  logic [bgns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgns_pkg::CFG_W-1:0]        cfg_data
);
  import bgns_pkg::*;

  // Column index into the line buffer, row count up to height+1
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  // Common width for position arithmetic: covers sizes, raw register values
  // and the row count plus one
  localparam int DIM_WH  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_TOP = (DIM_WH > (1 << CFG_W)) ? DIM_WH : (1 << CFG_W);
  localparam int PW      = $clog2(DIM_TOP + 3);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;

  // Stage 1: item waiting for its line buffer read
  logic             s1_valid;
  logic [CW-1:0]    s1_addr;
  logic             s1_bit;
  logic             s1_emit;
  logic             s1_border;
  logic             s1_last;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic accept;
  logic s1_adv;
  logic out_free;

  // The output register frees up in the same cycle its result transfers
  assign out_free = !out_valid || !out_stall;
  // Items without a result never wait on the output side
  assign s1_adv   = s1_valid && (!s1_emit || out_free);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Flush items enter the grid as empty cells
  logic in_bit;
  assign in_bit = (op == OP_CELL) ? cell_is_floor : 1'b0;

  // --------------------------------------------------------------------------
  // Position of the item at the input: which cell it completes and where the
  // next item lands
  // --------------------------------------------------------------------------
  logic [PW-1:0] width_raw;
  logic [PW-1:0] height_raw;
  logic [PW-1:0] w_eff;
  logic [PW-1:0] h_eff;
  logic [PW-1:0] col_p;
  logic [PW-1:0] row_p;
  logic [PW-1:0] em_row;
  logic [PW-1:0] em_col;
  logic [PW-1:0] col_inc;
  logic [PW-1:0] row_inc;
  logic          pos_started;
  logic          pos_emit;
  logic          pos_border;
  logic          pos_last;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  always_comb begin
    width_raw  = PW'(grid_width);
    height_raw = PW'(grid_height);

    // Clamp sizes into the supported range
    w_eff = width_raw;
    if (width_raw < PW'(DIM_MIN)) begin
      w_eff = PW'(DIM_MIN);
    end else if (width_raw > PW'(MAX_WIDTH)) begin
      w_eff = PW'(MAX_WIDTH);
    end
    h_eff = height_raw;
    if (height_raw < PW'(DIM_MIN)) begin
      h_eff = PW'(DIM_MIN);
    end else if (height_raw > PW'(MAX_HEIGHT)) begin
      h_eff = PW'(MAX_HEIGHT);
    end

    col_p = PW'(column_count);
    row_p = PW'(row_count);

    // Results start once one row plus one cell has gone by
    pos_started = (row_p >= PW'(2)) || ((row_p == PW'(1)) && (col_p != '0));

    // Emitted cell trails by one row plus one cell; column zero points at
    // the end of the row two rows up
    if (col_p == '0) begin
      em_row = row_p - PW'(2);
      em_col = w_eff - PW'(1);
    end else begin
      em_row = row_p - PW'(1);
      em_col = col_p - PW'(1);
    end

    pos_border = (em_row == '0) || (em_row >= h_eff - PW'(1)) ||
                 (em_col == '0) || (em_col >= w_eff - PW'(1));
    pos_last   = pos_started && (em_row == h_eff - PW'(1)) &&
                 (em_col >= w_eff - PW'(1));
    // Rows below the frame are drain positions only
    pos_emit   = pos_started && (em_row < h_eff);

    // Advance; wrap at row end; restart past the drain row or after the last cell
    col_inc = col_p + PW'(1);
    row_inc = row_p;
    if (col_inc >= w_eff) begin
      col_inc = '0;
      row_inc = row_p + PW'(1);
    end
    if (row_inc > h_eff + PW'(1)) begin
      col_inc = '0;
      row_inc = '0;
    end
    if (pos_last) begin
      col_inc = '0;
      row_inc = '0;
    end

    col_next = col_inc[CW-1:0];
    row_next = row_inc[RW-1:0];
  end

  // --------------------------------------------------------------------------
  // Line buffer: entry per column holds the two previous rows
  // --------------------------------------------------------------------------
  lb_entry_t lb_rd;
  lb_entry_t lb_wr;

  // Shift the column down by a row: the newer bit ages, the new cell enters
  assign lb_wr = '{older: lb_rd.newer, newer: s1_bit};

  bgns_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (column_count),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  // --------------------------------------------------------------------------
  // Window: the incoming column plus a chain of two column cells
  // --------------------------------------------------------------------------
  win_col_t new_col;
  win_col_t mid_col;
  win_sum_t new_sum;
  win_sum_t mid_sum;
  win_sum_t win_sum;
  logic     centre;
  logic     smooth_val;

  assign new_col = {s1_bit, lb_rd.newer, lb_rd.older};
  assign new_sum = col_ones(new_col);

  // Middle column of the window, shifts every transfer out of stage 1
  bgns_cell u_cell_mid (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_adv),
    .col_in   (new_col),
    .sum_in   (new_sum),
    .col      (mid_col),
    .sum_out  (mid_sum)
  );

  // Oldest column; what it holds drops off the window on the next shift
  bgns_cell u_cell_old (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_adv),
    .col_in   (mid_col),
    .sum_in   (mid_sum),
    .col      (),
    .sum_out  (win_sum)
  );

  // Centre of the window is the middle column, one row up
  assign centre     = mid_col[1];
  assign smooth_val = centre || (!s1_border && (win_sum > SUM_W'(FLOOR_LIMIT)));

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_DIM_RESET;
      grid_height  <= GRID_DIM_RESET;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end

      // Advance the raster position on every transfer in
      if (accept) begin
        column_count <= col_next;
        row_count    <= row_next;
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      // Hold a result until it transfers; refill in the same cycle
      if (s1_adv && s1_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr   <= column_count;
      s1_bit    <= in_bit;
      s1_emit   <= pos_emit;
      s1_border <= pos_border;
      s1_last   <= pos_last;
    end
    if (s1_adv && s1_emit) begin
      out_is_floor <= smooth_val;
      last_cell    <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BGNS_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, (out_valid && out_stall && s1_emit), "input stalled without a blocked result")
  `BGNS_ASSERT_NEXT(a_frame_restart, clk, rst, (accept && pos_last), (column_count == '0 && row_count == '0), "position not cleared after frame end")
  `BGNS_ASSERT_NEXT(a_no_repeat, clk, rst, (out_valid && !out_stall && !(s1_adv && s1_emit)), !out_valid, "transferred result offered again")

endmodule

`default_nettype wire

@@ sim/tb_binary_grid_neighbor_smoothing_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for binary_grid_neighbor_smoothing_top
// Streams binary grids through the 3x3 smoothing block with random idling on
// both channels, predicts every smoothed cell in a local model of the window
// and line buffers, and checks each output transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------

module tb_binary_grid_neighbor_smoothing_top;
  import bgns_pkg::*;

  // A result passes stage 1 and the output register before it can transfer; this adds margin before idling
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic out_is_floor;
    logic last_cell;
  } smoothed_cell_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic                 cell_is_floor;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_is_floor;
  logic                 last_cell;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Local copy of the block's state and size registers
  logic [DEF_MAX_WIDTH-1:0] row_older;
  logic [DEF_MAX_WIDTH-1:0] row_newer;
  logic [8:0]               nbhd_bits;
  int unsigned              col_pos;
  int unsigned              row_pos;
  logic [CFG_W-1:0]         grid_w_reg;
  logic [CFG_W-1:0]         grid_h_reg;

  // Smoothed cells still owed by the block, oldest first, in a small ring
  smoothed_cell_t owed_cells [16];
  logic [3:0]     owed_wr;
  logic [3:0]     owed_rd;
  int             owed_count;

  int mismatch_count = 0;
  int items_sent     = 0;
  int hold_left      = 0;
  int stall_left     = 0;
  bit gaps_on        = 1'b1;

  binary_grid_neighbor_smoothing_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .cell_is_floor (cell_is_floor),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_floor  (out_is_floor),
    .last_cell     (last_cell),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Size actually used by the block: out-of-range values clamp to [3, max]
  function automatic int unsigned effective_dim(input logic [CFG_W-1:0] raw,
                                                input int unsigned top);
    if (raw < DIM_MIN) return DIM_MIN;
    if (raw > top) return top;
    return raw;
  endfunction

  // Advance the local model by one accepted item; queue the cell it releases
  task automatic smooth_cell(input logic kind, input logic floor_in);
    int unsigned w, h, c, r, er, ec, slot;
    logic bit_in, val, border, is_last;
    smoothed_cell_t res;
    w = effective_dim(grid_w_reg, DEF_MAX_WIDTH);
    h = effective_dim(grid_h_reg, DEF_MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    // Flush items enter the window as non-floor cells
    bit_in = (kind == OP_CELL) ? floor_in : 1'b0;
    slot = c % DEF_MAX_WIDTH;
    // Shift in the new column: two rows up, one row up, current row
    nbhd_bits = {bit_in, row_newer[slot], row_older[slot], nbhd_bits[8:3]};
    row_older[slot] = row_newer[slot];
    row_newer[slot] = bit_in;
    is_last = 1'b0;
    if (r >= 2 || (r == 1 && c >= 1)) begin
      // The window is centered one row and one column behind the input
      if (c == 0) begin
        er = r - 2;
        ec = w - 1;
      end else begin
        er = r - 1;
        ec = c - 1;
      end
      border = (er == 0) || (er >= h - 1) || (ec == 0) || (ec >= w - 1);
      val = nbhd_bits[4];
      if (!border && $countones(nbhd_bits) > FLOOR_LIMIT) val = 1'b1;
      is_last = (er == h - 1) && (ec >= w - 1);
      // Rows below the frame emit nothing
      if (er < h) begin
        res.out_is_floor = val;
        res.last_cell    = is_last;
        owed_cells[owed_wr] = res;
        owed_wr++;
        owed_count++;
      end
    end
    if (is_last) begin
      // Frame done: the next item starts a new frame
      col_pos = 0;
      row_pos = 0;
    end else begin
      c = c + 1;
      if (c >= w) begin
        c = 0;
        r = r + 1;
      end
      // Far past the frame after a shrink: restart without a result
      if (r > h + 1) begin
        c = 0;
        r = 0;
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin : scoreboard
    smoothed_cell_t want;
    if (rst) begin
      row_older  = '0;
      row_newer  = '0;
      nbhd_bits  = '0;
      col_pos    = 0;
      row_pos    = 0;
      grid_w_reg = GRID_DIM_RESET;
      grid_h_reg = GRID_DIM_RESET;
      owed_wr    = '0;
      owed_rd    = '0;
      owed_count = 0;
    end else begin
      // Predict before checking so a result that transfers at its own item's edge would still match
      if (in_valid && !in_stall) smooth_cell(op, cell_is_floor);
      // A register write takes effect for the items after this edge
      if (cfg_write_en) begin
        if (cfg_index == REG_GRID_WIDTH) grid_w_reg = cfg_data;
        else grid_h_reg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (owed_count == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: out_is_floor=%0b last_cell=%0b",
                     out_is_floor, last_cell);
          mismatch_count++;
        end else begin
          want = owed_cells[owed_rd];
          owed_rd++;
          owed_count--;
          if (out_is_floor !== want.out_is_floor || last_cell !== want.last_cell) begin
            if (mismatch_count < 10)
              $display("mismatch: expected out_is_floor=%0b last_cell=%0b, %s%0b %s%0b",
                       want.out_is_floor, want.last_cell,
                       "got out_is_floor=", out_is_floor, "last_cell=", last_cell);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item and hold it until the transfer; starts and ends at a falling edge
  task automatic send_item(input logic kind, input logic floor_in);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= kind;
    cell_is_floor <= floor_in;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed cell has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both size registers on back-to-back cycles; call only when idle
  task automatic set_grid(input logic [CFG_W-1:0] width_val,
                          input logic [CFG_W-1:0] height_val);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_GRID_WIDTH;
    cfg_data     <= width_val;
    @(negedge clk);
    cfg_index    <= REG_GRID_HEIGHT;
    cfg_data     <= height_val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Raster cells at a floor density of density/8, then the drain items;
  // a quarter of the drain items are cells, which land below the frame and leave its results unchanged
  task automatic send_frame(input int unsigned cells, input int unsigned drain,
                            input int unsigned density);
    repeat (cells) send_item(OP_CELL, $urandom_range(0, 7) < density);
    repeat (drain) begin
      if ($urandom_range(0, 3) == 0) send_item(OP_CELL, 1'($urandom_range(0, 1)));
      else send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
    end
  endtask

  // Flush until the block sits at the start of a frame again
  task automatic flush_to_frame_start();
    while (col_pos != 0 || row_pos != 0) send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
  endtask

  // 3x3 frame whose center sees five floor cells and turns to floor
  task automatic test_window_rule();
    wait_for_drain();
    set_grid(8'd3, 8'd3);
    send_item(OP_CELL, 1'b1); send_item(OP_CELL, 1'b1); send_item(OP_CELL, 1'b1);
    send_item(OP_CELL, 1'b1); send_item(OP_CELL, 1'b0); send_item(OP_CELL, 1'b1);
    send_item(OP_CELL, 1'b0); send_item(OP_CELL, 1'b0); send_item(OP_CELL, 1'b0);
    // Drain with a mix of flushes and cells arriving after the frame
    send_item(OP_FLUSH, 1'b1); send_item(OP_CELL, 1'b1);
    send_item(OP_CELL, 1'b0); send_item(OP_FLUSH, 1'b0);
  endtask

  // Sizes below the minimum clamp to 3x3; a count of exactly four keeps the cell
  task automatic test_clamped_sizes();
    wait_for_drain();
    set_grid(8'd0, 8'd1);
    send_item(OP_CELL, 1'b1); send_item(OP_CELL, 1'b1); send_item(OP_CELL, 1'b0);
    send_item(OP_CELL, 1'b1); send_item(OP_CELL, 1'b0); send_item(OP_CELL, 1'b0);
    send_item(OP_CELL, 1'b0); send_item(OP_CELL, 1'b0); send_item(OP_CELL, 1'b1);
    repeat (4) send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
  endtask

  // Shrink the grid while a frame is half done: wrap a column, then restart a frame
  task automatic test_resize_mid_frame();
    wait_for_drain();
    set_grid(8'd5, 8'd5);
    // Stop at row 1, column 4, then narrow the rows to 3
    repeat (9) send_item(OP_CELL, 1'($urandom_range(0, 1)));
    wait_for_drain();
    set_grid(8'd3, 8'd4);
    flush_to_frame_start();
    // Reach row 7, then cut the height so the position lies beyond the frame
    wait_for_drain();
    set_grid(8'd3, 8'd10);
    repeat (21) send_item(OP_CELL, 1'($urandom_range(0, 1)));
    wait_for_drain();
    set_grid(8'd3, 8'd3);
    flush_to_frame_start();
  endtask

  // Raw sizes far above the limits: rows wrap at the widest supported width,
  // and a tall raw height runs on narrow rows; both frames are cut off
  task automatic test_register_extremes();
    wait_for_drain();
    set_grid(8'hFF, 8'd2);
    // One full row and two cells of the next: results start only after the wrap
    send_frame(DEF_MAX_WIDTH + 2, 0, $urandom_range(2, 6));
    wait_for_drain();
    set_grid(8'd3, 8'd3);
    flush_to_frame_start();
    wait_for_drain();
    set_grid(8'd3, 8'd200);
    send_frame(12, 0, $urandom_range(2, 6));
    wait_for_drain();
    set_grid(8'd3, 8'd3);
    flush_to_frame_start();
  endtask

  // Random small grids, back-to-back frames, and some cut-off frames
  task automatic test_random_frames();
    int start;
    int unsigned w, h;
    logic [CFG_W-1:0] wr, hr;
    start = items_sent;
    while (items_sent - start < 120) begin
      wait_for_drain();
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      wr = CFG_W'(w);
      hr = CFG_W'(h);
      // Now and then write a size below the minimum; it acts as 3
      if ($urandom_range(0, 9) == 0) begin
        wr = CFG_W'($urandom_range(0, 2));
        w  = 3;
      end
      if ($urandom_range(0, 9) == 0) begin
        hr = CFG_W'($urandom_range(0, 2));
        h  = 3;
      end
      set_grid(wr, hr);
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 5) == 0) begin
          // Cut the frame short; sometimes resize before realigning
          send_frame($urandom_range(1, w * h - 1), 0, $urandom_range(0, 8));
          if ($urandom_range(0, 1) == 1) begin
            wait_for_drain();
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            set_grid(CFG_W'(w), CFG_W'(h));
          end
          flush_to_frame_start();
        end else begin
          send_frame(w * h, w + 1, $urandom_range(0, 8));
        end
      end
    end
  endtask

  // Hold the output off long enough that the block backs up and stalls its input
  task automatic test_backpressure();
    wait_for_drain();
    set_grid(8'd8, 8'd6);
    @(posedge clk);
    hold_left = 200;
    @(negedge clk);
    send_frame(48, 9, $urandom_range(3, 6));
  endtask

  // Full rate on both sides, no idling at all
  task automatic test_steady_stream();
    wait_for_drain();
    gaps_on = 1'b0;
    set_grid(8'd10, 8'd7);
    send_frame(70, 11, $urandom_range(3, 6));
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_CELL;
    cell_is_floor = 1'b0;
    cfg_write_en  = 1'b0;
    cfg_index     = REG_GRID_WIDTH;
    cfg_data      = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_window_rule();
    test_clamped_sizes();
    test_resize_mid_frame();
    test_register_extremes();
    test_random_frames();
    test_backpressure();
    test_steady_stream();

    wait_for_drain();
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("binary_grid_neighbor_smoothing_top test passed");
    end else begin
      $display("binary_grid_neighbor_smoothing_top test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run
  initial begin
    #400000;
    $display("binary_grid_neighbor_smoothing_top test failed");
    $finish;
  end

endmodule
